// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the set table top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BST_ASSERT(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// next-cycle implication
`define BST_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Types and action codes shared by the set table and its cells.
// ----------------------------------------------------------------------------
package bst_pkg;

   localparam int ValueW = 32;
   localparam int ActionW = 2;
   localparam int CountFieldW = 5;

   typedef logic [ActionW-1:0] action_type;
   typedef logic signed [ValueW-1:0] value_type;

   localparam action_type ACT_CLEAR = 2'd0;
   localparam action_type ACT_INSERT = 2'd1;
   localparam action_type ACT_DELETE = 2'd2;
   localparam action_type ACT_QUERY = 2'd3;

   // broadcast from the table control to every cell
   typedef struct packed {
      logic clear;
      logic insert;
      logic delete;
   } cell_ctrl_type;

endpackage

// File: hdl/bounded_set_table_top.sv
// ----------------------------------------------------------------------------
// bounded_set_table_top
// Fixed-capacity set of distinct 32-bit values held in a chain of cells.
//
//   channel   ports                                  handshake
//   request   req_action, req_element_value          start & !busy
//   response  rsp_was_member .. rsp_is_empty         rsp_valid, one cycle
//
// A request is taken at an edge with start high and busy low; all cells
// compare against it at that edge. The next edge applies the action and the
// response strobes in the cycle after. A delete of a present value keeps busy
// high while the gap moves up the cell chain one slot per cycle.
// Reset empties the set. The response cannot be held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_set_table_top
   import bst_pkg::*;
#(
   parameter int SET_CAPACITY = 16
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  action_type             req_action,
   input  value_type              req_element_value,
   output logic                   rsp_valid,
   output logic                   rsp_was_member,
   output logic [CountFieldW-1:0] rsp_element_count,
   output logic                   rsp_is_full,
   output logic                   rsp_is_empty
);

   localparam int CountW = $clog2(SET_CAPACITY + 1);

   logic              accept;
   logic              apply_ff, apply_in;
   action_type        action_ff;
   value_type         key_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic              present;
   logic              hole_any;
   cell_ctrl_type     ctrl;

   logic [SET_CAPACITY-1:0] valid_vec;
   logic [SET_CAPACITY-1:0] hit_vec;
   logic [SET_CAPACITY-1:0] hole_vec;
   value_type               value_arr [SET_CAPACITY];

   logic                   rsp_valid_ff;
   logic                   rsp_was_member_ff;
   logic [CountFieldW-1:0] rsp_element_count_ff;
   logic                   rsp_is_full_ff;
   logic                   rsp_is_empty_ff;

   // request handshake
   assign hole_any = |hole_vec;
   assign busy     = apply_ff | hole_any;
   assign accept   = start & ~busy;
   assign apply_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_ff <= 1'b0;
      end else begin
         apply_ff <= apply_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_element_value;
      end
   end

   // action decode for the cells
   assign present     = |hit_vec;
   assign ctrl.clear  = apply_ff && (action_ff == ACT_CLEAR);
   assign ctrl.insert = apply_ff && (action_ff == ACT_INSERT) && !present;
   assign ctrl.delete = apply_ff && (action_ff == ACT_DELETE);

   // cell chain
   for (genvar k = 0; k < SET_CAPACITY; k++) begin : g_cell
      logic      prev_valid;
      logic      prev_hole;
      logic      next_valid;
      value_type next_value;

      if (k == 0) begin : g_first
         assign prev_valid = 1'b1;
         assign prev_hole  = 1'b0;
      end else begin : g_inner_lo
         assign prev_valid = valid_vec[k-1];
         assign prev_hole  = hole_vec[k-1];
      end

      if (k == SET_CAPACITY - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_value = '0;
      end else begin : g_inner_hi
         assign next_valid = valid_vec[k+1];
         assign next_value = value_arr[k+1];
      end

      bst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cmp_value  (req_element_value),
         .key_value  (key_ff),
         .prev_valid (prev_valid),
         .prev_hole  (prev_hole),
         .next_valid (next_valid),
         .next_value (next_value),
         .valid      (valid_vec[k]),
         .value      (value_arr[k]),
         .hit        (hit_vec[k]),
         .hole       (hole_vec[k])
      );
   end

   // element count after the action
   always_comb begin
      count_in = count_ff;
      if (apply_ff) begin
         case (action_ff)
            ACT_CLEAR: begin
               count_in = '0;
            end
            ACT_INSERT: begin
               if (!present && (count_ff < CountW'(SET_CAPACITY))) begin
                  count_in = count_ff + CountW'(1);
               end
            end
            ACT_DELETE: begin
               if (present) begin
                  count_in = count_ff - CountW'(1);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= apply_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_ff) begin
         rsp_was_member_ff    <= present;
         rsp_element_count_ff <= CountFieldW'(count_in);
         rsp_is_full_ff       <= (count_in == CountW'(SET_CAPACITY));
         rsp_is_empty_ff      <= (count_in == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_member    = rsp_was_member_ff;
   assign rsp_element_count = rsp_element_count_ff;
   assign rsp_is_full       = rsp_is_full_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;

   // checks
   `BST_ASSERT_NEXT(a_rsp_follows_apply, apply_ff, rsp_valid_ff,
      "response did not follow the apply cycle")
   `BST_ASSERT(a_valid_packed,
      (valid_vec & (valid_vec + SET_CAPACITY'(1))) == '0,
      "valid slots are not packed from slot zero")
   `BST_ASSERT(a_count_matches, busy || (CountW'($countones(valid_vec)) == count_ff),
      "element count disagrees with valid slots")
   `BST_ASSERT(a_single_hole, $onehot0(hole_vec),
      "more than one gap in the cell chain")
   `BST_ASSERT(a_single_hit, !apply_ff || $onehot0(hit_vec),
      "value stored in more than one slot")

endmodule

// File: hdl/bst_cell.sv
// ----------------------------------------------------------------------------
// bst_cell
// One set slot: holds a value and its valid bit, compares with the broadcast
// request value, takes a clear or append, passes a delete hole up the chain.
// ----------------------------------------------------------------------------
module bst_cell
   import bst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  value_type     cmp_value,
   input  value_type     key_value,
   input  logic          prev_valid,
   input  logic          prev_hole,
   input  logic          next_valid,
   input  value_type     next_value,
   output logic          valid,
   output value_type     value,
   output logic          hit,
   output logic          hole
);

   logic      valid_ff, valid_in;
   logic      hole_ff, hole_in;
   logic      hit_ff, hit_in;
   value_type value_ff, value_in;

   // membership compare, registered at every edge including the one that takes a request
   assign hit_in = valid_ff && (value_ff == cmp_value);

   // slot update: clear, append at the first free slot, open a gap on a delete hit, or close the gap
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      hole_in  = 1'b0;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         value_in = key_value;
      end else if (ctrl.delete && hit_ff) begin
         hole_in = 1'b1;
      end else if (hole_ff) begin
         // pull the upper neighbor down, or drop the last slot
         if (next_valid) begin
            value_in = next_value;
         end else begin
            valid_in = 1'b0;
         end
      end else if (prev_hole && valid_ff) begin
         hole_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hole_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hole_ff  <= hole_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign hit   = hit_ff;
   assign hole  = hole_ff;

endmodule
